>>> rtl/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types, constants and byte scaling / mixing functions for the
// differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATE_ABOVE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] DEADBAND_FLOOR_RST = 8'h05;
  localparam logic [7:0] SATURATE_ABOVE_RST = 8'hFA;

  localparam logic [7:0] FULL_SCALE = 8'hFF;

  // Input mode codes.
  localparam logic MODE_UPDATE  = 1'b0;
  localparam logic MODE_DISABLE = 1'b1;

  // Sign-magnitude drive: fwd set means the byte was at or above center.
  typedef struct packed {
    logic       fwd;
    logic [7:0] mag;
  } drive_t;

  // Mixed drives for both motors.
  typedef struct packed {
    drive_t left;
    drive_t right;
  } mix_t;

  // Command word handed to the bridge sequencer.
  typedef struct packed {
    logic valid;
    logic disable_all;
    mix_t mix;
  } cmd_t;

  // Turns a stick byte into a scaled, saturated and deadbanded drive.
  function automatic drive_t scale_byte(input logic [7:0] b, input logic [7:0] floor_v,
                                        input logic [7:0] sat_v);
    drive_t     d;
    logic [6:0] m7;
    logic [7:0] m;
    d.fwd = b[7];
    m7    = b[7] ? b[6:0] : ~b[6:0];
    m     = {m7, 1'b1};
    if (m > sat_v) begin
      m = FULL_SCALE;
    end
    if (m < floor_v) begin
      m = 8'h00;
    end
    d.mag = m;
    return d;
  endfunction

  // Mixes gas and steer into one side's drive.
  function automatic drive_t mix_side(input drive_t g, input drive_t s, input logic assist);
    drive_t d;
    d = '{fwd: 1'b0, mag: 8'h00};
    if (g.mag != 8'h00) begin
      if (g.fwd) begin
        if (assist) begin
          d = g;
        end else if (s.mag >= g.mag) begin
          d = '{fwd: 1'b1, mag: 8'h00};
        end else begin
          d = '{fwd: 1'b1, mag: g.mag - s.mag};
        end
      end else begin
        if (!assist) begin
          d = g;
        end else if (s.mag < g.mag) begin
          d = '{fwd: 1'b0, mag: g.mag - s.mag};
        end
      end
    end else if (s.mag != 8'h00) begin
      d = '{fwd: assist, mag: s.mag};
    end
    return d;
  endfunction

endpackage

>>> rtl/ddm_mix.sv
// ----------------------------------------------------------------------------
// ddm_mix
// Scales the gas and steer bytes and mixes them into left and right drives.
// ----------------------------------------------------------------------------
module ddm_mix (
  input  logic          [7:0] gas,
  input  logic          [7:0] steer,
  input  logic          [7:0] deadband_floor,
  input  logic          [7:0] saturate_above,
  output ddm_pkg::mix_t       mix
);

  ddm_pkg::drive_t g_drv;
  ddm_pkg::drive_t s_drv;

  // Scale both stick bytes.
  assign g_drv = ddm_pkg::scale_byte(gas, deadband_floor, saturate_above);
  assign s_drv = ddm_pkg::scale_byte(steer, deadband_floor, saturate_above);

  // Steer to the right assists the left motor, to the left the right motor.
  assign mix.left  = ddm_pkg::mix_side(g_drv, s_drv, s_drv.fwd);
  assign mix.right = ddm_pkg::mix_side(g_drv, s_drv, !s_drv.fwd);

endmodule

>>> rtl/ddm_bridge.sv
// ----------------------------------------------------------------------------
// ddm_bridge
// Holds the H-bridge pins and duties and steps through the snapshots of one
// command, one per cycle unless the output stalls, into the result register.
// ----------------------------------------------------------------------------
module ddm_bridge (
  input  logic                clk,
  input  logic                rst_n,
  input  ddm_pkg::cmd_t       cmd,
  output logic                cmd_done,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_left_fwd_on,
  output logic                out_left_rev_on,
  output logic          [7:0] out_left_fwd_duty,
  output logic          [7:0] out_left_rev_duty,
  output logic                out_right_fwd_on,
  output logic                out_right_rev_on,
  output logic          [7:0] out_right_fwd_duty,
  output logic          [7:0] out_right_rev_duty,
  output logic                out_dead_time_follows,
  output logic                out_last
);

  logic       lf_r, lr_r, rf_r, rr_r;
  logic       lf_nxt, lr_nxt, rf_nxt, rr_nxt;
  logic [7:0] lfd_r, lrd_r, rfd_r, rrd_r;
  logic [7:0] lfd_nxt, lrd_nxt, rfd_nxt, rrd_nxt;
  logic       out_valid_r, dead_r, last_r;
  logic       dead_nxt, last_nxt;
  logic       sw_l, sw_r, step;

  // A snapshot is produced whenever a command waits and the result register is free to load.
  assign step     = cmd.valid && (!out_valid_r || !out_stall);
  assign cmd_done = step && last_nxt;

  assign sw_l = cmd.mix.left.fwd ? !lf_r : !lr_r;
  assign sw_r = cmd.mix.right.fwd ? !rf_r : !rr_r;

  // Next snapshot: all off on a disable, else a left switch, else left load then a
  // right switch, else the final duties. Reloading a duty already loaded changes nothing.
  always_comb begin
    lf_nxt   = lf_r;
    lr_nxt   = lr_r;
    rf_nxt   = rf_r;
    rr_nxt   = rr_r;
    lfd_nxt  = lfd_r;
    lrd_nxt  = lrd_r;
    rfd_nxt  = rfd_r;
    rrd_nxt  = rrd_r;
    dead_nxt = 1'b0;
    last_nxt = 1'b1;
    if (cmd.disable_all) begin
      lf_nxt  = 1'b0;
      lr_nxt  = 1'b0;
      rf_nxt  = 1'b0;
      rr_nxt  = 1'b0;
      lfd_nxt = 8'h00;
      lrd_nxt = 8'h00;
      rfd_nxt = 8'h00;
      rrd_nxt = 8'h00;
    end else if (sw_l) begin
      lf_nxt   = cmd.mix.left.fwd;
      lr_nxt   = !cmd.mix.left.fwd;
      lfd_nxt  = 8'h00;
      lrd_nxt  = 8'h00;
      dead_nxt = 1'b1;
      last_nxt = 1'b0;
    end else begin
      if (cmd.mix.left.fwd) begin
        lfd_nxt = cmd.mix.left.mag;
      end else begin
        lrd_nxt = cmd.mix.left.mag;
      end
      if (sw_r) begin
        rf_nxt   = cmd.mix.right.fwd;
        rr_nxt   = !cmd.mix.right.fwd;
        rfd_nxt  = 8'h00;
        rrd_nxt  = 8'h00;
        dead_nxt = 1'b1;
        last_nxt = 1'b0;
      end else if (cmd.mix.right.fwd) begin
        rfd_nxt = cmd.mix.right.mag;
      end else begin
        rrd_nxt = cmd.mix.right.mag;
      end
    end
  end

  // Bridge state doubles as the result payload; it moves only on a step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_r        <= 1'b1;
      lr_r        <= 1'b0;
      rf_r        <= 1'b1;
      rr_r        <= 1'b0;
      lfd_r       <= 8'h00;
      lrd_r       <= 8'h00;
      rfd_r       <= 8'h00;
      rrd_r       <= 8'h00;
      out_valid_r <= 1'b0;
      dead_r      <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      if (step) begin
        lf_r   <= lf_nxt;
        lr_r   <= lr_nxt;
        rf_r   <= rf_nxt;
        rr_r   <= rr_nxt;
        lfd_r  <= lfd_nxt;
        lrd_r  <= lrd_nxt;
        rfd_r  <= rfd_nxt;
        rrd_r  <= rrd_nxt;
        dead_r <= dead_nxt;
        last_r <= last_nxt;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_left_fwd_on       = lf_r;
  assign out_left_rev_on       = lr_r;
  assign out_left_fwd_duty     = lfd_r;
  assign out_left_rev_duty     = lrd_r;
  assign out_right_fwd_on      = rf_r;
  assign out_right_rev_on      = rr_r;
  assign out_right_fwd_duty    = rfd_r;
  assign out_right_rev_duty    = rrd_r;
  assign out_dead_time_follows = dead_r;
  assign out_last              = last_r;

`ifndef ASSERT_OFF
  // A dead-time word is never the final word of a command.
  a_dead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dead_r |-> !last_r)
    else $error("dead-time word marked last");

  // A dead-time word has one motor fully idle.
  a_dead_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dead_r |->
      ((lfd_r == 8'h00) && (lrd_r == 8'h00)) || ((rfd_r == 8'h00) && (rrd_r == 8'h00)))
    else $error("dead-time word with both motors driven");

  // Both direction pins of one motor are never on together.
  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(lf_r && lr_r) && !(rf_r && rr_r))
    else $error("both direction pins of a motor set");

  // Bridge state holds while a result waits.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=>
      $stable({lf_r, lr_r, rf_r, rr_r, lfd_r, lrd_r, rfd_r, rrd_r}))
    else $error("bridge state changed while result stalled");
`endif

endmodule

>>> rtl/differential_drive_mixer_hbridge_core.sv
// Each input word gives one result per motor whose direction switches, plus the
// final word; the next word is taken as its final result is sent.
// The bridge sequencer emits one result per cycle into the result register unless stalled.
// Reset (synchronous, rst_n low): forward pins set, duties zero, registers at defaults.
// ----------------------------------------------------------------------------
// differential_drive_mixer_hbridge_core
// Arcade drive mixer: scales gas and steer sticks, mixes them into left and
// right sign-magnitude drives and sequences H-bridge dead-time snapshots.
// ----------------------------------------------------------------------------
module differential_drive_mixer_hbridge_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ddm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                        [7:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic                        [7:0] in_gas,
  input  logic                        [7:0] in_steer,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_left_fwd_on,
  output logic                              out_left_rev_on,
  output logic                        [7:0] out_left_fwd_duty,
  output logic                        [7:0] out_left_rev_duty,
  output logic                              out_right_fwd_on,
  output logic                              out_right_rev_on,
  output logic                        [7:0] out_right_fwd_duty,
  output logic                        [7:0] out_right_rev_duty,
  output logic                              out_dead_time_follows,
  output logic                              out_last
);

  logic          [7:0] floor_r, sat_r;
  logic                a_valid_r, a_mode_r;
  logic          [7:0] a_gas_r, a_steer_r;
  logic                in_take, cmd_done;
  ddm_pkg::mix_t       mix;
  ddm_pkg::cmd_t       cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= ddm_pkg::DEADBAND_FLOOR_RST;
      sat_r   <= ddm_pkg::SATURATE_ABOVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ddm_pkg::CFG_DEADBAND_FLOOR: floor_r <= cfg_data;
        ddm_pkg::CFG_SATURATE_ABOVE: sat_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: refills in the cycle its word sends the final result.
  assign in_stall = a_valid_r && !cmd_done;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (cmd_done) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_mode_r  <= in_mode;
      a_gas_r   <= in_gas;
      a_steer_r <= in_steer;
    end
  end

  // Stick scaling and mixing.
  ddm_mix u_mix (
    .gas            (a_gas_r),
    .steer          (a_steer_r),
    .deadband_floor (floor_r),
    .saturate_above (sat_r),
    .mix            (mix)
  );

  assign cmd.valid       = a_valid_r;
  assign cmd.disable_all = (a_mode_r == ddm_pkg::MODE_DISABLE);
  assign cmd.mix         = mix;

  // H-bridge state and snapshot sequencing.
  ddm_bridge u_bridge (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cmd_done              (cmd_done),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_left_fwd_on       (out_left_fwd_on),
    .out_left_rev_on       (out_left_rev_on),
    .out_left_fwd_duty     (out_left_fwd_duty),
    .out_left_rev_duty     (out_left_rev_duty),
    .out_right_fwd_on      (out_right_fwd_on),
    .out_right_rev_on      (out_right_rev_on),
    .out_right_fwd_duty    (out_right_fwd_duty),
    .out_right_rev_duty    (out_right_rev_duty),
    .out_dead_time_follows (out_dead_time_follows),
    .out_last              (out_last)
  );

endmodule

>>> verif/tb_differential_drive_mixer_hbridge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_drive_mixer_hbridge_core
// Self-checking bench for the arcade drive mixer. A queue-fed driver sends
// stick words in random bursts, and a monitor predicts the bridge snapshots
// for every accepted word and checks the result words in order. The receiver
// stalls on its own pattern. Thresholds are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_differential_drive_mixer_hbridge_core;

  localparam int MOTOR_LEFT   = 0;
  localparam int MOTOR_RIGHT  = 1;
  localparam int DUTY_FWD     = 0;
  localparam int DUTY_REV     = 1;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    logic       mode;
    logic [7:0] gas;
    logic [7:0] steer;
  } stick_word_t;

  typedef struct packed {
    logic       left_fwd_on;
    logic       left_rev_on;
    logic [7:0] left_fwd_duty;
    logic [7:0] left_rev_duty;
    logic       right_fwd_on;
    logic       right_rev_on;
    logic [7:0] right_fwd_duty;
    logic [7:0] right_rev_duty;
    logic       dead;
    logic       is_last;
  } bridge_word_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [ddm_pkg::CFG_IDX_W-1:0] cfg_index = ddm_pkg::CFG_DEADBAND_FLOOR;
  logic [7:0]                    cfg_data  = 8'h00;
  logic                          in_valid  = 1'b0;
  logic                          in_mode   = ddm_pkg::MODE_UPDATE;
  logic [7:0]                    in_gas    = 8'h80;
  logic [7:0]                    in_steer  = 8'h80;
  logic                          out_stall = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_left_fwd_on;
  logic                          out_left_rev_on;
  logic [7:0]                    out_left_fwd_duty;
  logic [7:0]                    out_left_rev_duty;
  logic                          out_right_fwd_on;
  logic                          out_right_rev_on;
  logic [7:0]                    out_right_fwd_duty;
  logic [7:0]                    out_right_rev_duty;
  logic                          out_dead_time_follows;
  logic                          out_last;

  differential_drive_mixer_hbridge_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_gas               (in_gas),
    .in_steer             (in_steer),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_left_fwd_on      (out_left_fwd_on),
    .out_left_rev_on      (out_left_rev_on),
    .out_left_fwd_duty    (out_left_fwd_duty),
    .out_left_rev_duty    (out_left_rev_duty),
    .out_right_fwd_on     (out_right_fwd_on),
    .out_right_rev_on     (out_right_rev_on),
    .out_right_fwd_duty   (out_right_fwd_duty),
    .out_right_rev_duty   (out_right_rev_duty),
    .out_dead_time_follows(out_dead_time_follows),
    .out_last             (out_last)
  );

  // Predicted bridge state: thresholds, direction pins and the four duties.
  logic [7:0]   floor_cfg   = ddm_pkg::DEADBAND_FLOOR_RST;
  logic [7:0]   sat_cfg     = ddm_pkg::SATURATE_ABOVE_RST;
  logic         fwd_pin [2] = '{1'b1, 1'b1};
  logic         rev_pin [2] = '{1'b0, 1'b0};
  logic [7:0]   duty_mem [4] = '{8'h00, 8'h00, 8'h00, 8'h00};

  stick_word_t  stick_q[$];
  bridge_word_t bridge_q[$];
  int           err_count   = 0;
  int           idle_cycles = 0;
  int           gap_left    = 0;
  int           burst_left  = 0;
  int           stall_run   = 0;
  logic         in_fire     = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Scales one stick byte into a sign-magnitude drive.
  function automatic ddm_pkg::drive_t stick_drive(input logic [7:0] b);
    ddm_pkg::drive_t d;
    logic [7:0]      m;
    d.fwd = (b >= 8'd128);
    m     = d.fwd ? (b - 8'd128) : (8'd127 - b);
    m     = 8'(2 * m + 1);
    // Saturation first, so a saturated value is never cleared by the floor.
    if (m > sat_cfg) m = 8'hFF;
    if (m < floor_cfg) m = 8'h00;
    d.mag = m;
    return d;
  endfunction

  // Blends gas and steer for one side; assist is set when steer helps it.
  function automatic ddm_pkg::drive_t blend_side(input ddm_pkg::drive_t g,
                                                 input ddm_pkg::drive_t s,
                                                 input logic assist);
    ddm_pkg::drive_t d;
    d.fwd = 1'b0;
    d.mag = 8'h00;
    if (g.mag == 8'h00) begin
      if (s.mag != 8'h00) begin
        d.fwd = assist;
        d.mag = s.mag;
      end
    end else if (g.fwd) begin
      d.fwd = 1'b1;
      if (assist) d.mag = g.mag;
      else if (s.mag < g.mag) d.mag = g.mag - s.mag;
    end else begin
      if (!assist) d = g;
      else if (s.mag < g.mag) d.mag = g.mag - s.mag;
    end
    return d;
  endfunction

  function automatic bridge_word_t capture_bridge(input logic dead, input logic fin);
    bridge_word_t b;
    b.left_fwd_on    = fwd_pin[MOTOR_LEFT];
    b.left_rev_on    = rev_pin[MOTOR_LEFT];
    b.left_fwd_duty  = duty_mem[2 * MOTOR_LEFT + DUTY_FWD];
    b.left_rev_duty  = duty_mem[2 * MOTOR_LEFT + DUTY_REV];
    b.right_fwd_on   = fwd_pin[MOTOR_RIGHT];
    b.right_rev_on   = rev_pin[MOTOR_RIGHT];
    b.right_fwd_duty = duty_mem[2 * MOTOR_RIGHT + DUTY_FWD];
    b.right_rev_duty = duty_mem[2 * MOTOR_RIGHT + DUTY_REV];
    b.dead           = dead;
    b.is_last        = fin;
    return b;
  endfunction

  // Applies one drive to a motor; a direction change first yields a dead-time word.
  task automatic apply_motor(input int m, input ddm_pkg::drive_t d);
    logic switching;
    switching = d.fwd ? !fwd_pin[m] : !rev_pin[m];
    if (switching) begin
      duty_mem[2 * m + DUTY_FWD] = 8'h00;
      duty_mem[2 * m + DUTY_REV] = 8'h00;
      fwd_pin[m] = d.fwd;
      rev_pin[m] = !d.fwd;
      bridge_q.push_back(capture_bridge(1'b1, 1'b0));
    end
    duty_mem[2 * m + (d.fwd ? DUTY_FWD : DUTY_REV)] = d.mag;
  endtask

  // Works out every bridge word that one accepted stick word causes.
  task automatic predict_bridge(input stick_word_t w);
    ddm_pkg::drive_t g;
    ddm_pkg::drive_t s;
    ddm_pkg::drive_t left_d;
    ddm_pkg::drive_t right_d;
    if (w.mode == ddm_pkg::MODE_DISABLE) begin
      for (int m = 0; m < 2; m++) begin
        fwd_pin[m] = 1'b0;
        rev_pin[m] = 1'b0;
      end
      for (int i = 0; i < 4; i++) duty_mem[i] = 8'h00;
    end else begin
      g       = stick_drive(w.gas);
      s       = stick_drive(w.steer);
      left_d  = blend_side(g, s, s.fwd);
      right_d = blend_side(g, s, !s.fwd);
      apply_motor(MOTOR_LEFT, left_d);
      apply_motor(MOTOR_RIGHT, right_d);
    end
    bridge_q.push_back(capture_bridge(1'b0, 1'b1));
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: predicts on input acceptance and checks each accepted result word.
  always @(posedge clk) begin
    bridge_word_t want;
    logic         out_fire;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire) predict_bridge('{mode: in_mode, gas: in_gas, steer: in_steer});
    if (out_fire) begin
      if (bridge_q.size() == 0) begin
        err_count++;
        $display("%0t: result word arrived with no expectation waiting", $time);
      end else begin
        want = bridge_q.pop_front();
        check_field("left_fwd_on", want.left_fwd_on, out_left_fwd_on);
        check_field("left_rev_on", want.left_rev_on, out_left_rev_on);
        check_field("left_fwd_duty", want.left_fwd_duty, out_left_fwd_duty);
        check_field("left_rev_duty", want.left_rev_duty, out_left_rev_duty);
        check_field("right_fwd_on", want.right_fwd_on, out_right_fwd_on);
        check_field("right_rev_on", want.right_rev_on, out_right_rev_on);
        check_field("right_fwd_duty", want.right_fwd_duty, out_right_fwd_duty);
        check_field("right_rev_duty", want.right_rev_duty, out_right_rev_duty);
        check_field("dead_time_follows", want.dead, out_dead_time_follows);
        check_field("last", want.is_last, out_last);
      end
    end
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
  end

  // Driver: sends queued stick words in bursts separated by random gaps.
  always @(negedge clk) begin
    stick_word_t w;
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stick_q.size() > 0) begin
        w = stick_q.pop_front();
        in_valid <= 1'b1;
        in_mode  <= w.mode;
        in_gas   <= w.gas;
        in_steer <= w.steer;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: long and short free runs, short and long stall runs.
  always @(negedge clk) begin
    int unsigned r;
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(10, 40);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 3);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(4, 20);
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_stick(input logic mode, input logic [7:0] gas, input logic [7:0] steer);
    stick_q.push_back('{mode: mode, gas: gas, steer: steer});
  endtask

  // Stick bytes weighted toward the extremes and the deadband around center.
  function automatic logic [7:0] pick_stick_byte();
    int unsigned r;
    logic [7:0]  extremes [8] = '{8'd0, 8'd1, 8'd126, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    r = $urandom_range(0, 99);
    if (r < 15) return extremes[$urandom_range(0, 7)];
    if (r < 40) return 8'(128 + $urandom_range(0, 12) - 6);
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic fill_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        push_stick(ddm_pkg::MODE_DISABLE, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end else begin
        push_stick(ddm_pkg::MODE_UPDATE, pick_stick_byte(), pick_stick_byte());
      end
    end
  endtask

  // Waits until no word is pending, in flight or expected.
  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (stick_q.size() != 0 || in_valid || bridge_q.size() != 0);
  endtask

  task automatic write_cfg(input logic [ddm_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == ddm_pkg::CFG_DEADBAND_FLOOR) floor_cfg = val;
    else sat_cfg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence: reset, directed words, then random phases over threshold settings.
  initial begin
    logic [7:0] floors [NUM_PHASES];
    logic [7:0] sats [NUM_PHASES];
    floors = '{8'd0, 8'd255, 8'd128, 8'($urandom_range(0, 255)), 8'd0, 8'd255, 8'd5,
               8'($urandom_range(0, 40))};
    sats   = '{8'd255, 8'd0, 8'd128, 8'($urandom_range(0, 255)), 8'd0, 8'd255, 8'd250,
               8'($urandom_range(200, 255))};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at reset thresholds: center, full deflections, disables,
    // deadband and saturation edges, steer overpowering gas.
    push_stick(ddm_pkg::MODE_UPDATE, 8'd128, 8'd128);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd255, 8'd128);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd0, 8'd128);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd128, 8'd255);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd128, 8'd0);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd255, 8'd255);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd255, 8'd0);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd0, 8'd255);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd0, 8'd0);
    push_stick(ddm_pkg::MODE_DISABLE, 8'd255, 8'd0);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd200, 8'd100);
    push_stick(ddm_pkg::MODE_DISABLE, 8'd0, 8'd255);
    push_stick(ddm_pkg::MODE_DISABLE, 8'd170, 8'd85);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd129, 8'd130);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd130, 8'd127);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd252, 8'd128);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd253, 8'd128);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd200, 8'd240);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd60, 8'd200);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd60, 8'd30);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd180, 8'd180);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd76, 8'd76);
    push_stick(ddm_pkg::MODE_DISABLE, 8'd85, 8'd170);
    push_stick(ddm_pkg::MODE_UPDATE, 8'd127, 8'd128);
    fill_random(60);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      write_cfg(ddm_pkg::CFG_DEADBAND_FLOOR, floors[p]);
      write_cfg(ddm_pkg::CFG_SATURATE_ABOVE, sats[p]);
      fill_random(48);
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && bridge_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
